// ===== hw/rtl/fifo_queue_with_remove_min_core_assert.svh =====
// assertion macros shared by the queue checker
`ifndef FIFO_QUEUE_WITH_REMOVE_MIN_CORE_ASSERT_SVH
`define FIFO_QUEUE_WITH_REMOVE_MIN_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define FQRM_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property whose consequence must hold in the cycle after the condition
`define FQRM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fqrm_pkg.sv =====
// shared types and constants for the fifo queue with remove-min
`timescale 1ns / 1ps

package fqrm_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH   = 2'd0,
        K_POP    = 2'd1,
        K_PEEK   = 2'd2,
        K_REMOVE = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_SHIFT,
        OP_REMOVE
    } op_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        op_t  op;
        logic clear;
    } cell_ctrl_t;

    // scan token passed from a cell to its younger neighbor
    typedef struct packed {
        logic tok;
        logic have;
    } link_t;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        status_t           status;
        logic [OCC_W-1:0]  occ;
    } res_t;

endpackage

// ===== hw/rtl/fifo_queue_with_remove_min_core.sv =====
// top level of the fifo queue with remove-min, built as a chain of cells
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------
//  input   | in_valid / in_stall | kind, data_in
//  output  | out_valid/out_stall | item_out, status, occupancy
//
// push, pop and peek need no scan; an item can follow every cycle while in_stall is low
// remove-min runs a scan: a scan token walks the cell chain one
// cell per cycle carrying the running minimum, then the chosen entry is shifted out
// reset clears the entry count, the cell valid bits and the scan state
// results go through a two-entry buffer; input stalls during a scan or
// while both buffer entries hold results
`timescale 1ns / 1ps

module fifo_queue_with_remove_min_core
    import fqrm_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [ITEM_W-1:0] data_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [ITEM_W-1:0] item_out,
    output logic [STATUS_W-1:0]      status,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    cell_ctrl_t                   ctrl;
    logic                         scan_start;
    logic                         in_accept;
    logic                         full, empty;
    logic                         take_any;
    logic                         res_valid;
    logic                         skid_full;
    res_t                         res, res_out;
    logic signed [DATA_WIDTH-1:0] push_data;

    // chain wiring: valid and data toward the older side, token toward the younger
    logic [DEPTH+1:0]             vld_chain;
    logic signed [DATA_WIDTH-1:0] data_chain [DEPTH+1];
    link_t                        tok_chain  [DEPTH+1];
    logic signed [DATA_WIDTH-1:0] min_chain  [DEPTH+1];
    logic [DEPTH-1:0]             cell_take;

    assign push_data  = DATA_WIDTH'(data_in);
    assign in_stall   = (state_reg != S_IDLE) || skid_full;
    assign in_accept  = in_valid && !in_stall;
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign take_any   = |cell_take;

    // a remove-min on a non-empty queue launches the scan token
    assign scan_start = in_accept && (kind_t'(kind) == K_REMOVE) && !empty;

    assign vld_chain[0]       = 1'b1;
    assign vld_chain[DEPTH+1] = 1'b0;
    assign data_chain[DEPTH]  = '0;
    assign tok_chain[0].tok   = scan_start;
    assign tok_chain[0].have  = 1'b0;
    assign min_chain[0]       = '0;

    // row of cells, oldest entry in cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        fqrm_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .push_data   (push_data),
            .left_valid  (vld_chain[i]),
            .link_in     (tok_chain[i]),
            .min_in      (min_chain[i]),
            .right_valid (vld_chain[i+2]),
            .right_data  (data_chain[i+1]),
            .valid       (vld_chain[i+1]),
            .data        (data_chain[i]),
            .link_out    (tok_chain[i+1]),
            .min_out     (min_chain[i+1]),
            .take        (cell_take[i])
        );
    end

    // request decode and scan sequencing
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ctrl.op    = OP_HOLD;
        ctrl.clear = take_any;
        res_valid  = 1'b0;
        res.item   = '0;
        res.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_valid = 1'b1;
                    if (kind_t'(kind) == K_PUSH)
                    begin
                        if (full)
                            res.status = ST_FULL;
                        else
                        begin
                            ctrl.op    = OP_PUSH;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (empty)
                        res.status = ST_EMPTY;
                    else
                    begin
                        unique case (kind_t'(kind))
                            K_PUSH: ;
                            K_POP:
                            begin
                                ctrl.op    = OP_SHIFT;
                                res.item   = ITEM_W'(data_chain[0]);
                                count_next = count_reg - CNT_W'(1);
                            end
                            K_PEEK:
                                res.item = ITEM_W'(data_chain[0]);
                            K_REMOVE:
                            begin
                                res_valid  = 1'b0;
                                state_next = S_SCAN;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                // token has left the last cell: the minimum and its place are known
                if (tok_chain[DEPTH].tok)
                begin
                    ctrl.op    = OP_REMOVE;
                    res_valid  = 1'b1;
                    res.item   = ITEM_W'(min_chain[DEPTH]);
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
        endcase
        res.occ = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // result buffer
    fqrm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out),
        .skid_full (skid_full)
    );

    assign item_out  = res_out.item;
    assign status    = res_out.status;
    assign occupancy = res_out.occ;

endmodule

// ===== hw/rtl/fqrm_cell.sv =====
// one queue cell: holds an entry and takes part in the min scan
`timescale 1ns / 1ps

module fqrm_cell
    import fqrm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctrl_t                   ctrl,
    input  logic signed [DATA_WIDTH-1:0] push_data,
    input  logic                         left_valid,
    input  link_t                        link_in,
    input  logic signed [DATA_WIDTH-1:0] min_in,
    input  logic                         right_valid,
    input  logic signed [DATA_WIDTH-1:0] right_data,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] data,
    output link_t                        link_out,
    output logic signed [DATA_WIDTH-1:0] min_out,
    output logic                         take
);

    logic                         valid_reg, valid_next;
    logic signed [DATA_WIDTH-1:0] data_reg, data_next;
    logic                         tok_reg, have_reg, shift_reg, shift_next;
    logic signed [DATA_WIDTH-1:0] min_reg;

    // this cell becomes the running minimum when it beats what came from the left
    assign take = link_in.tok && valid_reg && (!link_in.have || (data_reg < min_in));

    // entry update
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctrl.op)
            OP_HOLD: ;
            OP_PUSH:
            begin
                if (left_valid && !valid_reg)
                begin
                    valid_next = 1'b1;
                    data_next  = push_data;
                end
            end
            OP_SHIFT:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            OP_REMOVE:
            begin
                if (shift_reg)
                begin
                    valid_next = right_valid;
                    data_next  = right_data;
                end
            end
        endcase
    end

    // shift mark: set from the chosen cell onward, cleared behind a newer choice
    always_comb
    begin
        priority if (take)
            shift_next = 1'b1;
        else if (ctrl.clear)
            shift_next = 1'b0;
        else if (link_in.tok)
            shift_next = 1'b1;
        else
            shift_next = shift_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
            have_reg  <= 1'b0;
            shift_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= link_in.tok;
            have_reg  <= link_in.have || take;
            shift_reg <= shift_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        min_reg  <= take ? data_reg : min_in;
    end

    assign valid         = valid_reg;
    assign data          = data_reg;
    assign link_out.tok  = tok_reg;
    assign link_out.have = have_reg;
    assign min_out       = min_reg;

endmodule

// ===== hw/rtl/fqrm_out_buf.sv =====
// two-entry result buffer between the queue and the output channel
`timescale 1ns / 1ps

module fqrm_out_buf
    import fqrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  res_t res,
    output logic out_valid,
    input  logic out_stall,
    output res_t res_out,
    output logic skid_full
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic drain;

    assign drain = out_valid_reg && !out_stall;

    // move results forward as the output side takes them
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || drain)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = res_valid;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign res_out   = out_reg;
    assign skid_full = skid_valid_reg;

endmodule

// ===== hw/rtl/fqrm_checker.sv =====
// port-level checks for the fifo queue with remove-min, bound to the top level
`timescale 1ns / 1ps
`include "fifo_queue_with_remove_min_core_assert.svh"

module fqrm_checker
    import fqrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [ITEM_W-1:0] item_out,
    input logic [STATUS_W-1:0]      status,
    input logic [OCC_W-1:0]         occupancy
);

    // a stalled result stays offered
    `FQRM_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a request on an empty queue returns zero and leaves it empty
    `FQRM_ASSERT_NOW(a_empty_zero, !(out_valid && status == ST_EMPTY) || (item_out == '0 && occupancy == '0), "empty result not zero")

    // a dropped push returns zero with the queue at capacity
    `FQRM_ASSERT_NOW(a_full_cap, !(out_valid && status == ST_FULL) || (item_out == '0 && occupancy == OCC_W'(DEPTH)), "full result wrong")

    // only the three defined status codes appear
    `FQRM_ASSERT_NOW(a_status_code, !out_valid || status == ST_OK || status == ST_EMPTY || status == ST_FULL, "undefined status code")

endmodule

bind fifo_queue_with_remove_min_core fqrm_checker #(
    .DEPTH (DEPTH)
) u_fqrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .item_out  (item_out),
    .status    (status),
    .occupancy (occupancy)
);

// ===== tb/tb_top.sv =====
// testbench for the fifo queue with remove-min: directed and random requests checked in order
`timescale 1ns / 1ps

module tb_top;
    import fqrm_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int RAND_ITEMS  = 1050;
    localparam int DRAIN_WAIT  = 60;
    localparam int IDLE_PCT    = 12;
    localparam int QUIET_START = 1200;
    localparam int QUIET_END   = 2400;

    typedef struct {
        kind_t                    op;
        logic signed [ITEM_W-1:0] value;
    } request_t;

    typedef struct {
        logic signed [ITEM_W-1:0] item;
        status_t                  stat;
        logic [OCC_W-1:0]         occ;
    } answer_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [KIND_W-1:0]        kind;
    logic signed [ITEM_W-1:0] data_in;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [ITEM_W-1:0] item_out;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;

    request_t                 pending_reqs[$];
    answer_t                  expected_answers[$];
    logic signed [ITEM_W-1:0] held_values[$];
    request_t                 next_req;
    logic                     in_taken;
    int                       err_count;
    int                       cycle_no;
    logic                     quiet;

    fifo_queue_with_remove_min_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .item_out  (item_out),
        .status    (status),
        .occupancy (occupancy)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // queue the next request for the driver
    task automatic add_request(input kind_t op, input logic signed [ITEM_W-1:0] value);
        request_t r;
        r.op    = op;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    // data mix: small values for ties, extremes, and full-range words
    function automatic logic signed [ITEM_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return int'($urandom_range(0, 6)) - 3;
        else if (sel == 4)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // update the queue image with one request and record the answer it yields
    task automatic predict_answer(input kind_t op, input logic signed [ITEM_W-1:0] value);
        answer_t a;
        int      best;
        a.item = '0;
        a.stat = ST_OK;
        if (op == K_PUSH)
        begin
            if (held_values.size() >= QDEPTH)
                a.stat = ST_FULL;
            else
                held_values.push_back(value);
        end
        else if (held_values.size() == 0)
            a.stat = ST_EMPTY;
        else if (op == K_POP)
            a.item = held_values.pop_front();
        else if (op == K_PEEK)
            a.item = held_values[0];
        else
        begin
            // oldest of the smallest values leaves, the rest keep their order
            best = 0;
            for (int p = 1; p < held_values.size(); p++)
                if (held_values[p] < held_values[best])
                    best = p;
            a.item = held_values[best];
            held_values.delete(best);
        end
        a.occ = OCC_W'(held_values.size());
        expected_answers.push_back(a);
    endtask

    task automatic report_mismatch(input string what, input logic [ITEM_W-1:0] got,
                                   input logic [ITEM_W-1:0] want);
        err_count++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_no, what, got, want);
    endtask

    // cycle count and the stretch without idling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_no <= 0;
        else
            cycle_no <= cycle_no + 1;
    end

    assign quiet = (cycle_no >= QUIET_START) && (cycle_no < QUIET_END);

    // input acceptance feeds the predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                predict_answer(kind_t'(kind), data_in);
        end
    end

    // driver: new item only once the current one is taken or none is shown
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= K_PUSH;
            data_in  <= '0;
        end
        else if (!in_valid || in_taken)
        begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                next_req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                kind     <= next_req.op;
                data_in  <= next_req.value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n || quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : monitor
        answer_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
                report_mismatch("unexpected result item", item_out, '0);
            else
            begin
                a = expected_answers.pop_front();
                if (item_out !== a.item)
                    report_mismatch("item_out", item_out, a.item);
                if (status !== a.stat)
                    report_mismatch("status", status, a.stat);
                if (occupancy !== a.occ)
                    report_mismatch("occupancy", occupancy, a.occ);
            end
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int    gen_occ;
        int    mode;
        int    push_pct;
        kind_t op;

        err_count = 0;
        rst_n     = 1'b0;

        // empty queue requests, extremes, equal minima, full queue
        add_request(K_POP, 32'sh12345678);
        add_request(K_PEEK, -32'sd1);
        add_request(K_REMOVE, 32'sh80000000);
        add_request(K_PUSH, 32'sh7fffffff);
        add_request(K_PUSH, 32'sh80000000);
        add_request(K_PUSH, 32'sh0);
        add_request(K_PUSH, -32'sd1);
        add_request(K_PUSH, 32'sh80000000);
        add_request(K_PEEK, 32'sh0);
        add_request(K_REMOVE, 32'sh0);
        add_request(K_REMOVE, 32'sh0);
        add_request(K_POP, 32'sh0);
        for (int i = 0; i < 14; i++)
            add_request(K_PUSH, (i % 3 == 0) ? 32'sh7fffffff : int'(i % 4) - 2);
        add_request(K_PUSH, 32'sh55aa55aa);
        add_request(K_REMOVE, -32'sd1);

        // random part, occupancy tracked; push share changes every 40 requests to drift toward full and empty
        gen_occ  = QDEPTH - 1;
        mode     = 1;
        push_pct = 45;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                mode     = $urandom_range(0, 2);
                push_pct = (mode == 0) ? 70 : (mode == 1) ? 45 : 20;
            end
            if ($urandom_range(0, 99) < push_pct)
                op = K_PUSH;
            else
                op = kind_t'($urandom_range(1, 3));
            add_request(op, pick_value());
            if (op == K_PUSH && gen_occ < QDEPTH)
                gen_occ++;
            else if ((op == K_POP || op == K_REMOVE) && gen_occ > 0)
                gen_occ--;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== fifo_queue_with_remove_min_core.f =====
+incdir+hw/rtl
hw/rtl/fqrm_pkg.sv
hw/rtl/fqrm_cell.sv
hw/rtl/fqrm_out_buf.sv
hw/rtl/fifo_queue_with_remove_min_core.sv
hw/rtl/fqrm_checker.sv
tb/tb_top.sv
